FILE: rtl/core/sliding_window_reuse_counter_macros.svh
// Assertion macros used by the sliding window reuse counter RTL.
`ifndef SLIDING_WINDOW_REUSE_COUNTER_MACROS_SVH
`define SLIDING_WINDOW_REUSE_COUNTER_MACROS_SVH
`ifndef ASSERT_OFF
// Checks that the consequent holds in the same cycle as the antecedent.
`define SWRC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define SWRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SWRC_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define SWRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/core/swrc_pkg.sv
// Shared widths, reset values and register indexes of the sliding window reuse counter.
`default_nettype none

package swrc_pkg;

   // Widths of the fixed transaction fields and registers.
   localparam int FLOW_KEY_W      = 16;
   localparam int REUSE_COUNT_W   = 16;
   localparam int WINDOW_LENGTH_W = 13;
   localparam int STEP_LENGTH_W   = 16;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 16;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // Register indexes of the configuration port.
   localparam csr_index_type CSR_WINDOW_LENGTH = 2'd0;
   localparam csr_index_type CSR_STEP_LENGTH   = 2'd1;

   // Register values after reset.
   localparam logic [WINDOW_LENGTH_W-1:0] WINDOW_LENGTH_RESET = 13'd4096;
   localparam logic [STEP_LENGTH_W-1:0]   STEP_LENGTH_RESET   = 16'd1024;

   // The reuse tally stops at this value.
   localparam logic [REUSE_COUNT_W-1:0] REUSE_MAX = 16'hFFFF;

endpackage

`default_nettype wire

FILE: rtl/core/sliding_window_reuse_counter.sv
// Sliding window reuse counter. Each request transaction carries one flow key; the block counts
// it as a reuse when the same key is among the last window_length keys, and after every
// step_length requests it sends one response transaction with the reuse count of that step
// (saturating at 65535) and starts a new step. Keys are kept in a ring memory of WINDOW_DEPTH
// entries and a per-key occupancy memory of KEY_SPACE entries. A request is not issued while the
// one before it is in stage 1: each key needs two writes to the occupancy memory, which has a
// single write port. A request passes from the input register through stages 1 and 2, and a
// step's response is pushed into the response queue from stage 2. The response queue holds two
// responses; while one waits, a request is issued only when no earlier request is in its counting
// stage, and while two wait, requests are held. After reset, and after every write of window_length,
// the occupancy memory is cleared one entry per clock, and while that pass runs only the one request
// held in the input register is taken; configuration writes are taken at any time.
`default_nettype none
`include "sliding_window_reuse_counter_macros.svh"

module sliding_window_reuse_counter #(
   parameter int WINDOW_DEPTH = 4096,
   parameter int KEY_SPACE    = 65536
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel.
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [swrc_pkg::FLOW_KEY_W-1:0]       req_flow_key,
   // Response channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [swrc_pkg::REUSE_COUNT_W-1:0]    rsp_reuse_count,
   // Configuration write port.
   input  logic                                  csr_write_enable,
   input  swrc_pkg::csr_index_type               csr_index,
   input  logic [swrc_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   import swrc_pkg::*;

   localparam int RING_AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int WIN_W   = $clog2(WINDOW_DEPTH + 1);
   localparam int OCC_W   = WIN_W;
   localparam int KEY_AW  = $clog2(KEY_SPACE);
   localparam int CMP_W   = (WIN_W > WINDOW_LENGTH_W) ? WIN_W : WINDOW_LENGTH_W;
   localparam logic [KEY_AW-1:0] CLEAR_LAST = KEY_AW'(KEY_SPACE - 1);
   localparam logic [1:0] OUT_COUNT_FULL = 2'd2;

   // Configuration registers.
   logic [WINDOW_LENGTH_W-1:0] window_length_ff, window_length_in;
   logic [STEP_LENGTH_W-1:0]   step_length_ff, step_length_in;
   logic                       flush;

   // Window bookkeeping.
   logic [RING_AW-1:0] ring_pos_ff, ring_pos_in;
   logic [WIN_W-1:0]   filled_ff, filled_in;
   logic [WIN_W-1:0]   win_eff;
   logic [CMP_W-1:0]   win_wide;
   logic [RING_AW-1:0] pos_cur;
   logic [WIN_W-1:0]   pos_next_wide;
   logic               evict_cur;

   // Clearing pass over the occupancy memory.
   logic              clear_active_ff, clear_active_in;
   logic [KEY_AW-1:0] clear_addr_ff, clear_addr_in;

   // Input register.
   logic                  prep_valid_ff, prep_valid_in;
   logic [FLOW_KEY_W-1:0] prep_key_ff;
   logic [KEY_AW-1:0]     key_cur;
   logic                  req_accept;
   logic                  issue;

   // Stage 1: ring and key count reads in flight.
   logic               s1_valid_ff;
   logic [KEY_AW-1:0]  s1_key_ff;
   logic [RING_AW-1:0] s1_pos_ff;
   logic               s1_evict_ff;

   // Stage 2: count update and report.
   logic              s2_valid_ff;
   logic [KEY_AW-1:0] s2_key_ff;
   logic [KEY_AW-1:0] s2_old_ff;
   logic [OCC_W-1:0]  s2_ckey_ff;
   logic              s2_evict_ff;
   logic [OCC_W-1:0]  ckey_fwd;
   logic [OCC_W-1:0]  cold_fwd;
   logic              same_key;
   logic              reuse;
   logic              old_wr_en;

   // Stage 3: second write of the occupancy memory.
   logic s3_valid_ff;

   // Writes of the most recent item, kept for forwarding.
   logic              fw_old_en_ff, fw_old_en_in;
   logic [KEY_AW-1:0] fw_old_addr_ff;
   logic [OCC_W-1:0]  fw_old_val_ff;
   logic              fw_key_en_ff, fw_key_en_in;
   logic [KEY_AW-1:0] fw_key_addr_ff;
   logic [OCC_W-1:0]  fw_key_val_ff;

   // Step tally.
   logic [STEP_LENGTH_W-1:0] step_pos_ff, step_pos_in;
   logic [STEP_LENGTH_W-1:0] step_pos_next;
   logic [STEP_LENGTH_W-1:0] step_eff;
   logic [REUSE_COUNT_W-1:0] tally_ff, tally_in;
   logic [REUSE_COUNT_W-1:0] tally_next;
   logic                     emit;

   // Response queue.
   logic [REUSE_COUNT_W-1:0] out_data_ff [2];
   logic                     out_wr_ptr_ff, out_wr_ptr_in;
   logic                     out_rd_ptr_ff, out_rd_ptr_in;
   logic [1:0]               out_count_ff, out_count_in;
   logic                     out_push;
   logic                     out_pop;

   // Memory ports.
   logic              occ_we;
   logic [KEY_AW-1:0] occ_waddr;
   logic [OCC_W-1:0]  occ_wdata;
   logic [KEY_AW-1:0] occ_raddr;
   logic [OCC_W-1:0]  occ_rdata;
   logic [KEY_AW-1:0] ring_rdata;

   // Key reduction into the key space.
   generate
      if (KEY_SPACE >= (1 << FLOW_KEY_W)) begin : g_key_wide
         assign key_cur = KEY_AW'(prep_key_ff);
      end else if ((KEY_SPACE & (KEY_SPACE - 1)) == 0) begin : g_key_pow2
         assign key_cur = prep_key_ff[KEY_AW-1:0];
      end else begin : g_key_div
         // The quotient comes from a multiply by a rounded-up reciprocal, exact for 16-bit keys.
         localparam int SHIFT   = FLOW_KEY_W + KEY_AW;
         localparam int RECIP_W = FLOW_KEY_W + 2;
         localparam int PROD_W  = FLOW_KEY_W + RECIP_W;
         localparam longint unsigned RECIP_FULL =
            ((64'd1 << SHIFT) + 64'(KEY_SPACE) - 64'd1) / 64'(KEY_SPACE);
         localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

         logic [PROD_W-1:0]     quot_prod;
         logic [FLOW_KEY_W-1:0] quot_in;
         logic [FLOW_KEY_W-1:0] quot_ff;
         logic [FLOW_KEY_W-1:0] quot_back;

         assign quot_prod = PROD_W'(req_flow_key) * PROD_W'(RECIP);
         assign quot_in   = FLOW_KEY_W'(quot_prod >> SHIFT);

         always_ff @(posedge clock) begin
            if (req_accept) begin
               quot_ff <= quot_in;
            end
         end

         assign quot_back = quot_ff * FLOW_KEY_W'(KEY_SPACE);
         assign key_cur   = KEY_AW'(prep_key_ff - quot_back);
      end
   endgenerate

   // Effective window and step lengths.
   always_comb begin
      win_wide = CMP_W'(window_length_ff);
      if (window_length_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (win_wide > CMP_W'(WINDOW_DEPTH)) begin
         win_eff = WIN_W'(WINDOW_DEPTH);
      end else begin
         win_eff = WIN_W'(win_wide);
      end
      step_eff = (step_length_ff == '0) ? STEP_LENGTH_W'(1) : step_length_ff;
   end

   // Issue an item only when stage 1 is empty and the response queue can take its report.
   assign issue = prep_valid_ff && !s1_valid_ff && !clear_active_ff &&
                  ((out_count_ff == 2'd0) || ((out_count_ff == 2'd1) && !s2_valid_ff));
   assign req_stall  = prep_valid_ff && !issue;
   assign req_accept = req_valid && !req_stall;

   // Ring slot and eviction decision for the item being issued.
   always_comb begin
      pos_cur = (WIN_W'(ring_pos_ff) >= win_eff) ? '0 : ring_pos_ff;
      evict_cur = (filled_ff >= win_eff);
      pos_next_wide = WIN_W'(pos_cur) + WIN_W'(1);
   end

   // Configuration writes.
   always_comb begin
      window_length_in = window_length_ff;
      step_length_in   = step_length_ff;
      flush            = 1'b0;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: begin
               window_length_in = csr_write_data[WINDOW_LENGTH_W-1:0];
               flush            = 1'b1;
            end
            CSR_STEP_LENGTH: begin
               step_length_in = csr_write_data[STEP_LENGTH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Count forwarding from the previous item's writes, then the update of this item.
   always_comb begin
      if (fw_key_en_ff && (fw_key_addr_ff == s2_key_ff)) begin
         ckey_fwd = fw_key_val_ff;
      end else if (fw_old_en_ff && (fw_old_addr_ff == s2_key_ff)) begin
         ckey_fwd = fw_old_val_ff;
      end else begin
         ckey_fwd = s2_ckey_ff;
      end
      if (fw_key_en_ff && (fw_key_addr_ff == s2_old_ff)) begin
         cold_fwd = fw_key_val_ff;
      end else if (fw_old_en_ff && (fw_old_addr_ff == s2_old_ff)) begin
         cold_fwd = fw_old_val_ff;
      end else begin
         cold_fwd = occ_rdata;
      end
      reuse     = (ckey_fwd != '0);
      same_key  = s2_evict_ff && (s2_old_ff == s2_key_ff);
      old_wr_en = s2_valid_ff && s2_evict_ff && !same_key && (cold_fwd != '0);
   end

   // Step tally and report.
   always_comb begin
      tally_next    = (reuse && (tally_ff != REUSE_MAX)) ? tally_ff + REUSE_COUNT_W'(1) : tally_ff;
      step_pos_next = step_pos_ff + STEP_LENGTH_W'(1);
      emit          = (step_pos_next >= step_eff);
      out_push      = s2_valid_ff && emit;
      out_pop       = rsp_valid && !rsp_stall;
   end

   // Next state of the control registers.
   always_comb begin
      prep_valid_in = prep_valid_ff;
      if (req_accept) begin
         prep_valid_in = 1'b1;
      end else if (issue) begin
         prep_valid_in = 1'b0;
      end

      ring_pos_in = ring_pos_ff;
      filled_in   = filled_ff;
      if (flush) begin
         ring_pos_in = '0;
         filled_in   = '0;
      end else if (issue) begin
         ring_pos_in = (pos_next_wide >= win_eff) ? '0 : RING_AW'(pos_next_wide);
         filled_in   = evict_cur ? filled_ff : filled_ff + WIN_W'(1);
      end

      clear_active_in = clear_active_ff;
      clear_addr_in   = clear_addr_ff;
      if (flush) begin
         clear_active_in = 1'b1;
         clear_addr_in   = '0;
      end else if (clear_active_ff) begin
         clear_addr_in = clear_addr_ff + KEY_AW'(1);
         if (clear_addr_ff == CLEAR_LAST) begin
            clear_active_in = 1'b0;
         end
      end

      fw_old_en_in = fw_old_en_ff;
      fw_key_en_in = fw_key_en_ff;
      if (flush) begin
         fw_old_en_in = 1'b0;
         fw_key_en_in = 1'b0;
      end else if (s2_valid_ff) begin
         fw_old_en_in = old_wr_en;
         fw_key_en_in = !same_key;
      end

      step_pos_in = step_pos_ff;
      tally_in    = tally_ff;
      if (s2_valid_ff) begin
         if (emit) begin
            step_pos_in = '0;
            tally_in    = '0;
         end else begin
            step_pos_in = step_pos_next;
            tally_in    = tally_next;
         end
      end

      out_wr_ptr_in = out_push ? !out_wr_ptr_ff : out_wr_ptr_ff;
      out_rd_ptr_in = out_pop ? !out_rd_ptr_ff : out_rd_ptr_ff;
      case ({out_push, out_pop})
         2'b10:   out_count_in = out_count_ff + 2'd1;
         2'b01:   out_count_in = out_count_ff - 2'd1;
         default: out_count_in = out_count_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_LENGTH_RESET;
         step_length_ff   <= STEP_LENGTH_RESET;
         ring_pos_ff      <= '0;
         filled_ff        <= '0;
         clear_active_ff  <= 1'b1;
         clear_addr_ff    <= '0;
         prep_valid_ff    <= 1'b0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         s3_valid_ff      <= 1'b0;
         fw_old_en_ff     <= 1'b0;
         fw_key_en_ff     <= 1'b0;
         step_pos_ff      <= '0;
         tally_ff         <= '0;
         out_wr_ptr_ff    <= 1'b0;
         out_rd_ptr_ff    <= 1'b0;
         out_count_ff     <= '0;
      end else begin
         window_length_ff <= window_length_in;
         step_length_ff   <= step_length_in;
         ring_pos_ff      <= ring_pos_in;
         filled_ff        <= filled_in;
         clear_active_ff  <= clear_active_in;
         clear_addr_ff    <= clear_addr_in;
         prep_valid_ff    <= prep_valid_in;
         s1_valid_ff      <= issue;
         s2_valid_ff      <= s1_valid_ff;
         s3_valid_ff      <= s2_valid_ff;
         fw_old_en_ff     <= fw_old_en_in;
         fw_key_en_ff     <= fw_key_en_in;
         step_pos_ff      <= step_pos_in;
         tally_ff         <= tally_in;
         out_wr_ptr_ff    <= out_wr_ptr_in;
         out_rd_ptr_ff    <= out_rd_ptr_in;
         out_count_ff     <= out_count_in;
      end
   end

   // Payload registers along the pipeline.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         prep_key_ff <= req_flow_key;
      end
      if (issue) begin
         s1_key_ff   <= key_cur;
         s1_pos_ff   <= pos_cur;
         s1_evict_ff <= evict_cur;
      end
      if (s1_valid_ff) begin
         s2_key_ff   <= s1_key_ff;
         s2_old_ff   <= ring_rdata;
         s2_ckey_ff  <= occ_rdata;
         s2_evict_ff <= s1_evict_ff;
      end
      if (s2_valid_ff) begin
         fw_old_addr_ff <= s2_old_ff;
         fw_old_val_ff  <= cold_fwd - OCC_W'(1);
         fw_key_addr_ff <= s2_key_ff;
         fw_key_val_ff  <= ckey_fwd + OCC_W'(1);
      end
      if (out_push) begin
         out_data_ff[out_wr_ptr_ff] <= tally_next;
      end
   end

   // Occupancy write port: clearing pass, then the decrement of the evicted key,
   // then the increment of the new key in the following cycle.
   always_comb begin
      occ_we    = 1'b0;
      occ_waddr = '0;
      occ_wdata = '0;
      if (clear_active_ff) begin
         occ_we    = 1'b1;
         occ_waddr = clear_addr_ff;
      end else if (old_wr_en) begin
         occ_we    = 1'b1;
         occ_waddr = s2_old_ff;
         occ_wdata = cold_fwd - OCC_W'(1);
      end else if (s3_valid_ff && fw_key_en_ff) begin
         occ_we    = 1'b1;
         occ_waddr = fw_key_addr_ff;
         occ_wdata = fw_key_val_ff;
      end
   end

   // The read port serves the new key at issue and the evicted key in the cycle after.
   assign occ_raddr = s1_valid_ff ? ring_rdata : key_cur;

   swrc_ram #(
      .WIDTH (OCC_W),
      .DEPTH (KEY_SPACE)
   ) u_occ_ram (
      .clock         (clock),
      .write_enable  (occ_we),
      .write_address (occ_waddr),
      .write_data    (occ_wdata),
      .read_address  (occ_raddr),
      .read_data     (occ_rdata)
   );

   swrc_ram #(
      .WIDTH (KEY_AW),
      .DEPTH (WINDOW_DEPTH)
   ) u_ring_ram (
      .clock         (clock),
      .write_enable  (s1_valid_ff),
      .write_address (s1_pos_ff),
      .write_data    (s1_key_ff),
      .read_address  (pos_cur),
      .read_data     (ring_rdata)
   );

   // Response channel.
   assign rsp_valid       = (out_count_ff != 2'd0);
   assign rsp_reuse_count = out_data_ff[out_rd_ptr_ff];

   // Checks on the pipeline.
   `SWRC_ASSERT_NEXT(a_issue_spacing, clock, reset, issue, !issue, "items issued back to back")
   `SWRC_ASSERT_SAME(a_out_room, clock, reset, out_push, out_count_ff != OUT_COUNT_FULL,
                     "report pushed into a full response queue")
   `SWRC_ASSERT_SAME(a_fill_bound, clock, reset, issue && evict_cur, filled_ff == win_eff,
                     "ring fill count above the window")

endmodule

`default_nettype wire

FILE: rtl/core/swrc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module swrc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              write_enable,
   input  logic [ADDR_W-1:0] write_address,
   input  logic [WIDTH-1:0]  write_data,
   input  logic [ADDR_W-1:0] read_address,
   output logic [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // A read in the same cycle as a write to that entry returns the old contents.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the sliding window reuse counter.
`timescale 1ns / 1ps

module tb_top;
   import swrc_pkg::*;

   localparam int WINDOW_DEPTH = 4096;
   localparam int KEY_SPACE    = 65536;
   // Cycles to let pass after the last expected report before touching the registers.
   localparam int DRAIN_CYCLES = 12;

   // Register indexes that the block does not implement.
   localparam csr_index_type CSR_SPARE_2 = 2'd2;
   localparam csr_index_type CSR_SPARE_3 = 2'd3;

   typedef enum int {STALL_HEAVY_RSP, STALL_HEAVY_REQ, STALL_NONE} stall_mode_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [FLOW_KEY_W-1:0]      req_flow_key = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [REUSE_COUNT_W-1:0]   rsp_reuse_count;
   logic                       csr_write_enable = 1'b0;
   csr_index_type              csr_index = CSR_WINDOW_LENGTH;
   logic [CSR_DATA_W-1:0]      csr_write_data = '0;

   // Keys waiting to be sent and reuse counts waiting to come back.
   logic [FLOW_KEY_W-1:0]      pending_keys[$];
   logic [REUSE_COUNT_W-1:0]   expected_counts[$];

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_idle_pct = 0;
   int unsigned error_count = 0;
   int unsigned keys_accepted = 0;
   int unsigned reports_checked = 0;
   int unsigned window_rewrites = 0;

   // Predicted block state.
   logic [FLOW_KEY_W-1:0]      window_keys[WINDOW_DEPTH];
   int unsigned                key_count[KEY_SPACE];
   int unsigned                next_slot = 0;
   int unsigned                slots_used = 0;
   int unsigned                step_items = 0;
   logic [REUSE_COUNT_W-1:0]   step_reuses = '0;
   logic [WINDOW_LENGTH_W-1:0] cfg_window = WINDOW_LENGTH_RESET;
   logic [STEP_LENGTH_W-1:0]   cfg_step = STEP_LENGTH_RESET;

   sliding_window_reuse_counter #(
      .WINDOW_DEPTH(WINDOW_DEPTH),
      .KEY_SPACE(KEY_SPACE)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_flow_key(req_flow_key),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_reuse_count(rsp_reuse_count),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Empties the window: no key is held any more.
   function automatic void flush_window();
      foreach (key_count[i]) key_count[i] = 0;
      next_slot = 0;
      slots_used = 0;
   endfunction

   // Appends one key to the send queue.
   function automatic void enqueue_key(input logic [FLOW_KEY_W-1:0] key);
      pending_keys.insert(pending_keys.size(), key);
   endfunction

   // Takes one key into the window and queues a report when the step completes.
   function automatic void account_flow_key(input logic [FLOW_KEY_W-1:0] key);
      int unsigned win;
      int unsigned step;
      int unsigned slot;
      logic [FLOW_KEY_W-1:0] oldest;
      win = (cfg_window == 0) ? 1 : cfg_window;
      if (win > WINDOW_DEPTH) win = WINDOW_DEPTH;
      step = (cfg_step == 0) ? 1 : cfg_step;
      slot = (next_slot >= win) ? 0 : next_slot;
      if (key_count[key] != 0 && step_reuses != REUSE_MAX) step_reuses++;
      // Once the window is full, the oldest key gives up one occurrence.
      if (slots_used >= win) begin
         oldest = window_keys[slot];
         if (key_count[oldest] != 0) key_count[oldest]--;
      end else begin
         slots_used++;
      end
      key_count[key]++;
      window_keys[slot] = key;
      slot++;
      next_slot = (slot >= win) ? 0 : slot;
      step_items++;
      if (step_items >= step) begin
         expected_counts.insert(expected_counts.size(), step_reuses);
         step_reuses = '0;
         step_items = 0;
      end
   endfunction

   // Request driver: offers queued keys and predicts each accepted transaction.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            account_flow_key(req_flow_key);
            keys_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_keys.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_flow_key <= pending_keys.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each report against the oldest prediction.
   always @(posedge clock) begin
      logic [REUSE_COUNT_W-1:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_counts.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual reuse_count %0d",
                        $time, rsp_reuse_count);
               error_count++;
            end else begin
               want = expected_counts.pop_front();
               reports_checked++;
               if (rsp_reuse_count !== want) begin
                  $display("%0t: reuse_count mismatch, expected %0d, actual %0d",
                           $time, want, rsp_reuse_count);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   // Waits until every key is taken and every report is back, then lets the pipeline settle.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_keys.size() != 0 || req_valid || expected_counts.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      if (idx == CSR_WINDOW_LENGTH) begin
         cfg_window = data[WINDOW_LENGTH_W-1:0];
         flush_window();
         window_rewrites++;
      end else if (idx == CSR_STEP_LENGTH) begin
         cfg_step = data;
      end
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_stall_mode(input stall_mode_type mode);
      case (mode)
         STALL_HEAVY_RSP: begin
            sender_idle_pct = 19;
            receiver_idle_pct = 67;
         end
         STALL_HEAVY_REQ: begin
            sender_idle_pct = 67;
            receiver_idle_pct = 19;
         end
         default: begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
      endcase
   endtask

   // One configuration followed by a burst of keys drawn from a small pool at a random base.
   task automatic run_phase(input bit rewrite_window, input logic [CSR_DATA_W-1:0] window_data,
                            input logic [CSR_DATA_W-1:0] step_data, input int unsigned count,
                            input int unsigned span, input stall_mode_type mode);
      logic [FLOW_KEY_W-1:0] base;
      wait_until_drained();
      if (rewrite_window) write_register(CSR_WINDOW_LENGTH, window_data);
      write_register(CSR_STEP_LENGTH, step_data);
      set_stall_mode(mode);
      base = FLOW_KEY_W'($urandom_range(0, KEY_SPACE - 1));
      repeat (count) enqueue_key(base + FLOW_KEY_W'($urandom_range(0, span)));
   endtask

   // Main sequence.
   initial begin
      logic [FLOW_KEY_W-1:0] corner_keys[16];
      logic [CSR_DATA_W-1:0] rand_window;
      corner_keys = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h5555, 16'hAAAA,
                      16'h5555, 16'h0000, 16'h00FF, 16'hFF00, 16'hAAAA, 16'h0001,
                      16'h0002, 16'h0001, 16'h8000, 16'h8000};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed corner keys with a report per key; spare register writes must be ignored.
      write_register(CSR_SPARE_2, 16'hFFFF);
      write_register(CSR_SPARE_3, 16'hFFFF);
      write_register(CSR_STEP_LENGTH, 16'd1);
      set_stall_mode(STALL_HEAVY_RSP);
      foreach (corner_keys[i]) enqueue_key(corner_keys[i]);

      // Zero window and zero step both act as one.
      run_phase(1'b1, 16'h0000, 16'h0000, 150, 3, STALL_HEAVY_RSP);
      // Oversized window clamps to the ring depth; the longest step sends nothing here.
      run_phase(1'b1, 16'hFFFF, 16'hFFFF, 300, 255, STALL_HEAVY_RSP);
      // Shrinking the step below the running count reports on the next key.
      run_phase(1'b0, 16'h0000, 16'd5, 200, 7, STALL_HEAVY_REQ);
      // Window of the full ring depth with the tally carried over the window rewrite.
      run_phase(1'b1, 16'd4096, 16'd64, 400, 1023, STALL_HEAVY_REQ);
      // Upper data bits above the window field are dropped.
      run_phase(1'b1, 16'hE007, 16'd3, 400, 15, STALL_HEAVY_REQ);
      run_phase(1'b1, 16'h0001, 16'd1, 100, 1, STALL_NONE);
      rand_window = CSR_DATA_W'($urandom_range(2, 200)) |
                    (CSR_DATA_W'($urandom_range(0, 7)) << WINDOW_LENGTH_W);
      run_phase(1'b1, rand_window, CSR_DATA_W'($urandom_range(1, 40)), 400, 511, STALL_NONE);

      wait_until_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d flow keys over eight configurations with %0d window rewrites,",
               keys_accepted, window_rewrites);
      $display("windows of 1 to 4096 keys and steps of 1 to 65535; %0d reports checked.",
               reports_checked);
      if (error_count == 0) begin
         $display("[sliding_window_reuse_counter] OK");
      end else begin
         $display("[sliding_window_reuse_counter] ERROR");
      end
      $finish;
   end

   // Watchdog: the slowest correct run, clearing passes included, is well under this.
   initial begin
      #20_000_000;
      $display("Timeout with %0d keys queued and %0d reports outstanding.",
               pending_keys.size(), expected_counts.size());
      $display("[sliding_window_reuse_counter] ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/swrc_pkg.sv
rtl/core/swrc_ram.sv
rtl/core/sliding_window_reuse_counter.sv
verif/tb_top.sv
